// ===== hw/rtl/lrutc_pkg.sv =====
// Package for the LRU tag cache directory.
// Shared field widths and the request kind type; no dependencies.
package lrutc_pkg;

  // Fixed payload widths
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned LINE_W = 3;

  // Request kind
  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_INSERT = 1'b1
  } kind_e;

endpackage

// ===== hw/rtl/lrutc_if.sv =====
// Request and response channel interfaces of the LRU tag cache directory.
// Depends on lrutc_pkg.
interface lrutc_req_if import lrutc_pkg::*; ();
  logic              valid;
  logic              ready;
  kind_e             kind;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

interface lrutc_rsp_if import lrutc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [LINE_W-1:0] line;

  modport source (output valid, output hit, output line, input ready);
  modport sink   (input valid, input hit, input line, output ready);
endinterface

// ===== hw/rtl/lrutc_victim.sv =====
// Replacement victim picker: lowest free line, else oldest line (lowest index on ties).
// Depends on lrutc_pkg; the age search is a comparator tree.
module lrutc_victim import lrutc_pkg::*; #(
  parameter int unsigned LINES    = 8,
  parameter int unsigned AGE_BITS = 16
) (
  input  logic [LINES-1:0]                valid_i,
  input  logic [LINES-1:0][AGE_BITS-1:0]  age_i,
  output logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] idx_o
);

  localparam int unsigned IDX_W  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned LEAVES = 1 << IDX_W;
  localparam int unsigned NODES  = 2 * LEAVES - 1;

  logic [AGE_BITS-1:0] node_age [NODES];
  logic [IDX_W-1:0]    node_idx [NODES];
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;

  // Max-age tournament, heap order; left child wins ties so lower index wins
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      node_age[LEAVES-1+i] = (i < LINES) ? age_i[i] : '0;
      node_idx[LEAVES-1+i] = IDX_W'(i);
    end
    for (int n = LEAVES - 2; n >= 0; n--) begin
      if (node_age[2*n+2] > node_age[2*n+1]) begin
        node_age[n] = node_age[2*n+2];
        node_idx[n] = node_idx[2*n+2];
      end else begin
        node_age[n] = node_age[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end
    end
  end

  // Lowest-numbered free line
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < LINES; i++) begin
      if (!free_found && !valid_i[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign idx_o = free_found ? free_idx : node_idx[0];

endmodule

// ===== hw/rtl/lru_tag_cache_policy.sv =====
// LRU tag cache directory: fully associative, age-counter replacement.
// Depends on lrutc_pkg, lrutc_if and lrutc_victim.
//
// Takes one request per clock cycle while the response register is free, and
// returns one response per request through the request register, then the
// response register. The directory update for a request (tag compare
// across all lines, victim choice, age update) completes combinationally
// between those two registers, so back-to-back requests always see the
// state left by the one before. A lookup hit or any insert sets the touched
// line's age to one and ages every other valid line by one, saturating; a
// lookup miss leaves the directory unchanged and returns line zero. Line
// storage sits in flip-flops; there is no clearing pass after reset.
module lru_tag_cache_policy import lrutc_pkg::*; #(
  parameter int unsigned LINES    = 8,
  parameter int unsigned AGE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrutc_req_if.sink  req_i,
  lrutc_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

  // Directory state
  logic [LINES-1:0]               line_valid_q, line_valid_d;
  logic [KEY_W-1:0]               line_key_q [LINES];
  logic [LINES-1:0][AGE_BITS-1:0] age_q, age_d;

  // Request register
  logic             s1_valid_q;
  kind_e            s1_kind_q;
  logic [KEY_W-1:0] s1_key_q;

  // Response register
  logic              rsp_valid_q;
  logic              rsp_hit_q, rsp_hit_d;
  logic [LINE_W-1:0] rsp_line_q, rsp_line_d;

  logic              rsp_free;
  logic              advance;
  logic              match_hit;
  logic [IDX_W-1:0]  match_idx;
  logic [IDX_W-1:0]  victim_idx;
  logic [IDX_W-1:0]  tgt_idx;
  logic              do_update;
  logic              do_fill;
  logic [IDX_W+LINE_W-1:0] line_ext;

  // Handshake
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign advance     = s1_valid_q && rsp_free;
  assign req_i.ready = !s1_valid_q || rsp_free;

  // Tag compare, lowest matching line wins
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = 0; i < LINES; i++) begin
      if (!match_hit && line_valid_q[i] && (line_key_q[i] == s1_key_q)) begin
        match_hit = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  lrutc_victim #(
    .LINES    (LINES),
    .AGE_BITS (AGE_BITS)
  ) u_victim (
    .valid_i (line_valid_q),
    .age_i   (age_q),
    .idx_o   (victim_idx)
  );

  assign tgt_idx   = match_hit ? match_idx : victim_idx;
  assign do_update = advance && (match_hit || (s1_kind_q == KIND_INSERT));
  assign do_fill   = advance && !match_hit && (s1_kind_q == KIND_INSERT);

  // Next valid bits and ages
  always_comb begin
    line_valid_d = line_valid_q;
    age_d        = age_q;
    if (do_fill) begin
      line_valid_d[tgt_idx] = 1'b1;
    end
    if (do_update) begin
      for (int i = 0; i < LINES; i++) begin
        if (IDX_W'(i) == tgt_idx) begin
          age_d[i] = AGE_BITS'(1);
        end else if (line_valid_q[i] && (age_q[i] != {AGE_BITS{1'b1}})) begin
          age_d[i] = age_q[i] + AGE_BITS'(1);
        end
      end
    end
  end

  // Response payload: line carries the low bits of the index
  assign line_ext   = {{LINE_W{1'b0}}, tgt_idx};
  assign rsp_hit_d  = match_hit;
  assign rsp_line_d = (match_hit || (s1_kind_q == KIND_INSERT)) ? line_ext[LINE_W-1:0] : '0;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      rsp_valid_q  <= 1'b0;
      line_valid_q <= '0;
      age_q        <= '0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (rsp_free) begin
        rsp_valid_q <= s1_valid_q;
      end
      line_valid_q <= line_valid_d;
      age_q        <= age_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_kind_q <= req_i.kind;
      s1_key_q  <= req_i.key;
    end
    if (advance) begin
      rsp_hit_q  <= rsp_hit_d;
      rsp_line_q <= rsp_line_d;
    end
    if (do_fill) begin
      line_key_q[tgt_idx] <= s1_key_q;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.hit   = rsp_hit_q;
  assign rsp_o.line  = rsp_line_q;

`ifndef NO_ASSERTIONS
  // Lines never drop out of the directory
  a_valid_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((line_valid_q & $past(line_valid_q)) == $past(line_valid_q)))
    else $error("valid line was lost");

  // Touched line is valid with age one afterwards
  a_touch_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_update |=> (line_valid_q[$past(tgt_idx)] && (age_q[$past(tgt_idx)] == AGE_BITS'(1))))
    else $error("touched line not valid with age one");

  // A lookup miss leaves the directory alone
  a_miss_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !match_hit && (s1_kind_q == KIND_LOOKUP)) |=>
      ($stable(age_q) && $stable(line_valid_q)))
    else $error("lookup miss changed directory state");

  // A new response only follows a request that left the request register
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(s1_valid_q))
    else $error("response without request");
`endif

endmodule

// ===== tb/tb_lru_tag_cache_policy.sv =====
// Self-checking testbench for the LRU tag cache directory (lru_tag_cache_policy).
// Uses lrutc_pkg and the lrutc_req_if / lrutc_rsp_if channel interfaces.
// Directed table, random key-pool traffic and a repeated-hit run, all scored in-line.
module tb_lru_tag_cache_policy;
  import lrutc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINES       = 8;
  localparam int unsigned AGE_BITS    = 16;
  localparam int          CLK_HALF    = 2;
  localparam int          RST_CYCLES  = 10;
  localparam int          RAND_ITEMS  = 1640;
  localparam int          POOL_SIZE   = 16;
  localparam int          SOAK_ITEMS  = 24;
  localparam int          DRAIN_WAIT  = 8;
  localparam int          STALL_LIMIT = 2000;
  localparam int          MAX_PRINTS  = 40;

  typedef struct {
    logic              hit;
    logic [LINE_W-1:0] line;
  } lru_rsp_t;

  // One row of directed stimulus; known = response typed in by hand
  typedef struct {
    kind_e             kind;
    logic [KEY_W-1:0]  key;
    bit                known;
    logic              hit;
    logic [LINE_W-1:0] line;
  } dir_row_t;

  localparam int N_ROWS = 20;
  dir_row_t dir_rows [N_ROWS] = '{
    // empty directory: nothing matches, not even key zero
    '{KIND_LOOKUP, 64'h0000_0000_0000_0000, 1'b1, 1'b0, 3'd0},
    '{KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 3'd0},
    // first fills go to the lowest free lines
    '{KIND_INSERT, 64'h0000_0000_0000_0000, 1'b1, 1'b0, 3'd0},
    '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 3'd1},
    '{KIND_LOOKUP, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 3'd0},
    '{KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 3'd1},
    // insert of a resident key
    '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 3'd1},
    // lookup miss leaves everything alone
    '{KIND_LOOKUP, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 3'd0},
    '{KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 3'd2},
    '{KIND_INSERT, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 3'd3},
    '{KIND_INSERT, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 3'd4},
    '{KIND_INSERT, 64'h0000_0000_0000_0001, 1'b1, 1'b0, 3'd5},
    '{KIND_INSERT, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 3'd6},
    '{KIND_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 3'd7},
    // directory full: evictions pick the oldest line
    '{KIND_INSERT, 64'h0000_0000_DEAD_BEEF, 1'b0, 1'b0, 3'd0},
    '{KIND_LOOKUP, 64'h0000_0000_0000_0000, 1'b0, 1'b0, 3'd0},
    '{KIND_INSERT, 64'h0000_0000_0000_0000, 1'b0, 1'b0, 3'd0},
    '{KIND_LOOKUP, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 3'd0},
    '{KIND_INSERT, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 3'd0},
    '{KIND_LOOKUP, 64'h0000_0000_0000_0001, 1'b0, 1'b0, 3'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  lrutc_req_if req_if ();
  lrutc_rsp_if rsp_if ();

  lru_tag_cache_policy #(
    .LINES    (LINES),
    .AGE_BITS (AGE_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // 4 ns clock
  always #CLK_HALF clk_i = ~clk_i;

  // Shadow directory
  bit                  dir_valid [LINES];
  logic [KEY_W-1:0]    dir_key   [LINES];
  logic [AGE_BITS-1:0] dir_age   [LINES];

  lru_rsp_t due_rsp_q [$];
  lru_rsp_t none_rsp = '{hit: 1'b0, line: '0};

  int n_errors;
  int n_lookup;
  int n_insert;
  int n_hit;
  int n_evict;
  int n_sat_hold;

  int burst_left;
  bit pacing_off;

  logic [31:0] stall_pat;
  logic [4:0]  stall_tick;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  // Apply one request to the shadow directory and return its response
  function automatic lru_rsp_t lru_access(input kind_e k, input logic [KEY_W-1:0] key);
    int       match;
    int       victim;
    lru_rsp_t r;
    logic [AGE_BITS-1:0] oldest;
    match  = -1;
    victim = -1;
    r      = none_rsp;
    if (k == KIND_INSERT) n_insert++;
    else n_lookup++;
    for (int i = 0; i < LINES; i++) begin
      if (match < 0 && dir_valid[i] && dir_key[i] == key) match = i;
    end
    if (match >= 0) begin
      r.hit  = 1'b1;
      r.line = LINE_W'(match);
      dir_age[match] = '0;
      n_hit++;
    end else if (k == KIND_INSERT) begin
      for (int i = 0; i < LINES; i++) begin
        if (victim < 0 && !dir_valid[i]) victim = i;
      end
      // all lines busy: lowest-numbered line among the oldest
      if (victim < 0) begin
        victim = 0;
        oldest = dir_age[0];
        for (int i = 1; i < LINES; i++) begin
          if (dir_age[i] > oldest) begin
            victim = i;
            oldest = dir_age[i];
          end
        end
        n_evict++;
      end
      dir_valid[victim] = 1'b1;
      dir_key[victim]   = key;
      dir_age[victim]   = '0;
      r.line = LINE_W'(victim);
    end
    // a lookup miss is the only request that does not age the directory
    if (match >= 0 || k == KIND_INSERT) begin
      for (int i = 0; i < LINES; i++) begin
        if (dir_valid[i]) begin
          if (dir_age[i] == '1) n_sat_hold++;
          else dir_age[i] = dir_age[i] + AGE_BITS'(1);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  task automatic flag_mismatch(input string what, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
    if (n_errors < MAX_PRINTS)
      $display("%0t ns MISMATCH %s: expected %0h, got %0h", $realtime, what, want, got);
    n_errors++;
  endtask

  // Idle gap on the request side
  task automatic req_gap();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
  endtask

  // Send one request and book its expected response on acceptance
  task automatic issue(input kind_e k, input logic [KEY_W-1:0] key, input bit known,
                       input lru_rsp_t known_rsp);
    lru_rsp_t want;
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.kind  <= k;
    req_if.key   <= key;
    do @(posedge clk_i); while (!req_if.ready);
    want = lru_access(k, key);
    due_rsp_q.push_back(known ? known_rsp : want);
    if (!pacing_off) begin
      if (burst_left == 0) begin
        req_gap();
        burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(0, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Response side stalls on a random 32-bit pattern that is redrawn each time its index wraps
  always @(negedge clk_i) begin
    if (stall_tick == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat = '1;
        1:       stall_pat = $urandom;
        2:       stall_pat = $urandom | $urandom;
        default: stall_pat = $urandom & $urandom;
      endcase
    end
    rsp_if.ready <= stall_pat[stall_tick];
    stall_tick = stall_tick + 5'd1;
  end

  // Score every response transaction against the oldest expectation
  always @(posedge clk_i) begin
    lru_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (due_rsp_q.size() == 0) begin
        flag_mismatch("unexpected response (hit/line)", '0,
                      KEY_W'({rsp_if.hit, rsp_if.line}));
      end else begin
        want = due_rsp_q.pop_front();
        if (rsp_if.hit !== want.hit)
          flag_mismatch("hit", KEY_W'(want.hit), KEY_W'(rsp_if.hit));
        if (rsp_if.line !== want.line)
          flag_mismatch("line", KEY_W'(want.line), KEY_W'(rsp_if.line));
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t ns watchdog: no transaction for %0d cycles, %0d responses outstanding",
             $realtime, STALL_LIMIT, due_rsp_q.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    lru_rsp_t    row_rsp;
    logic [KEY_W-1:0] soak_key;
    int          pool_top;
    kind_e       k;
    logic [KEY_W-1:0] key;

    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.kind   = KIND_LOOKUP;
    req_if.key    = '0;
    rsp_if.ready  = 1'b0;
    stall_pat     = '1;
    stall_tick    = '0;
    burst_left    = 0;
    pacing_off    = 1'b0;
    pool_top      = POOL_SIZE - 1;
    for (int i = 0; i < LINES; i++) begin
      dir_valid[i] = 1'b0;
      dir_key[i]   = '0;
      dir_age[i]   = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_key();
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (RST_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (dir_rows[i]) begin
      row_rsp.hit  = dir_rows[i].hit;
      row_rsp.line = dir_rows[i].line;
      issue(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].known, row_rsp);
    end

    // Random traffic over a key pool; small pool windows give many hits,
    // the full pool and fresh keys force evictions
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) pool_top = $urandom_range(0, 1) ? 5 : POOL_SIZE - 1;
      key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_top)] : rand_key();
      k   = $urandom_range(0, 1) ? KIND_INSERT : KIND_LOOKUP;
      issue(k, key, 1'b0, none_rsp);
    end

    // Back-to-back hits on one line while every other line keeps aging
    soak_key   = rand_key();
    pacing_off = 1'b1;
    issue(KIND_INSERT, soak_key, 1'b0, none_rsp);
    for (int n = 0; n < SOAK_ITEMS; n++) issue(KIND_LOOKUP, soak_key, 1'b0, none_rsp);
    pacing_off = 1'b0;

    // Evict the oldest lines, then a short random tail
    for (int n = 0; n < 3; n++) issue(KIND_INSERT, rand_key(), 1'b0, none_rsp);
    issue(KIND_LOOKUP, soak_key, 1'b0, none_rsp);
    for (int n = 0; n < 30; n++) begin
      key = ($urandom_range(0, 1)) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : soak_key;
      k   = $urandom_range(0, 1) ? KIND_INSERT : KIND_LOOKUP;
      issue(k, key, 1'b0, none_rsp);
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;

    // Drain outstanding responses, then allow the pipeline to settle
    while (due_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (due_rsp_q.size() != 0)
      flag_mismatch("responses never returned", '0, KEY_W'(due_rsp_q.size()));

    $display("Covered %0d lookups and %0d inserts: %0d hits, %0d evictions of a full directory",
             n_lookup, n_insert, n_hit, n_evict);
    $display("Ages held at saturation %0d times; %0d mismatches", n_sat_hold, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
